/* hw/rtl/magma_block_cipher_top_assert.svh */
// Assertion macros for the Magma cipher pipeline.
// Each macro expects the signals clk and arst_n in the scope where it is used.
`ifndef MAGMA_BLOCK_CIPHER_TOP_ASSERT_SVH
`define MAGMA_BLOCK_CIPHER_TOP_ASSERT_SVH

`define MAGMA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("magma pipeline assertion failed");

`define MAGMA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("magma pipeline assertion failed");

`endif

/* hw/rtl/magma_pkg.sv */
`default_nettype none

package magma_pkg;

	localparam int NUM_ROUNDS   = 32;
	localparam int NUM_KEYS     = 8;
	localparam int ROT          = 11;
	localparam int CFG_IDX_W    = 8;
	localparam int KEY_IDX_W    = 3;

	typedef logic [31:0] word_t;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;

	typedef struct packed {
		logic  kind;
		word_t a1;
		word_t a0;
	} stage_t;

	localparam logic [3:0] SBOX [8][16] = '{
		'{4'hc, 4'h4, 4'h6, 4'h2, 4'ha, 4'h5, 4'hb, 4'h9,
		  4'he, 4'h8, 4'hd, 4'h7, 4'h0, 4'h3, 4'hf, 4'h1},
		'{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'ha, 4'h5, 4'hc,
		  4'h1, 4'he, 4'h4, 4'h7, 4'hb, 4'hd, 4'h0, 4'hf},
		'{4'hb, 4'h3, 4'h5, 4'h8, 4'h2, 4'hf, 4'ha, 4'hd,
		  4'he, 4'h1, 4'h7, 4'h4, 4'hc, 4'h9, 4'h6, 4'h0},
		'{4'hc, 4'h8, 4'h2, 4'h1, 4'hd, 4'h4, 4'hf, 4'h6,
		  4'h7, 4'h0, 4'ha, 4'h5, 4'h3, 4'he, 4'h9, 4'hb},
		'{4'h7, 4'hf, 4'h5, 4'ha, 4'h8, 4'h1, 4'h6, 4'hd,
		  4'h0, 4'h9, 4'h3, 4'he, 4'hb, 4'h4, 4'h2, 4'hc},
		'{4'h5, 4'hd, 4'hf, 4'h6, 4'h9, 4'h2, 4'hc, 4'ha,
		  4'hb, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'he, 4'h0},
		'{4'h8, 4'he, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hc,
		  4'hf, 4'h4, 4'hb, 4'h0, 4'hd, 4'ha, 4'h3, 4'h7},
		'{4'h1, 4'h7, 4'he, 4'hd, 4'h0, 4'h5, 4'h8, 4'h3,
		  4'h4, 4'hf, 4'ha, 4'h6, 4'h9, 4'hc, 4'hb, 4'h2}
	};

	// Encryption schedule: words 0..7 three times, then 7..0.
	function automatic key_idx_t enc_key_idx(input int r);
		key_idx_t low;
		low = key_idx_t'(r);
		if (r < 24) begin
			return low;
		end
		return ~low;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/magma_if.sv */
`default_nettype none

interface magma_in_if;
	logic                valid;
	logic                ready;
	logic                kind;
	logic [63:0]         block_in;

	modport source (output valid, output kind, output block_in, input ready);
	modport sink (input valid, input kind, input block_in, output ready);
endinterface

interface magma_out_if;
	logic                valid;
	logic                ready;
	logic [63:0]         block_out;

	modport source (output valid, output block_out, input ready);
	modport sink (input valid, input block_out, output ready);
endinterface

interface magma_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [magma_pkg::CFG_IDX_W-1:0]   index;
	logic [31:0]                       data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/magma_round.sv */
`default_nettype none

module magma_feistel_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 up_valid,
	output logic                up_ready,
	input  magma_pkg::stage_t   up_data,
	input  magma_pkg::word_t    key,
	output logic                dn_valid,
	input  wire                 dn_ready,
	output magma_pkg::stage_t   dn_data
);

	magma_pkg::word_t  sum;
	magma_pkg::word_t  sub;
	magma_pkg::word_t  rot;
	magma_pkg::stage_t nxt;
	logic              valid_s1;
	magma_pkg::stage_t data_s1;

	always_comb begin
		sum = up_data.a0 + key;
		for (int i = 0; i < 8; i++) begin
			sub[4*i +: 4] = magma_pkg::SBOX[i][sum[4*i +: 4]];
		end
		rot = {sub[31-magma_pkg::ROT:0], sub[31:32-magma_pkg::ROT]};
		nxt.kind = up_data.kind;
		nxt.a0   = up_data.a1 ^ rot;
		nxt.a1   = up_data.a0;
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

`default_nettype wire

/* hw/rtl/magma_block_cipher_top.sv */
// Magma block cipher, one Feistel round per pipeline stage (32 stages).
// Throughput: one 64-bit block per cycle; stalls fill bubbles before blocking input.
// Reset clears all stage valid bits and all eight key words to zero.
`default_nettype none

module magma_block_cipher_top (
	input  wire             clk,
	input  wire             arst_n,
	magma_in_if.sink        blk_in,
	magma_out_if.source     blk_out,
	magma_cfg_if.sink       cfg
);

	localparam int NR = magma_pkg::NUM_ROUNDS;

	magma_pkg::word_t  key_q [magma_pkg::NUM_KEYS];
	magma_pkg::stage_t sd    [NR+1];
	logic              sv    [NR+1];
	logic              sr    [NR+1];
	magma_pkg::word_t  rk    [NR];
	logic [NR-1:0]     sv_vec;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < magma_pkg::NUM_KEYS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg.valid && cfg.ready &&
			     (cfg.index < magma_pkg::CFG_IDX_W'(magma_pkg::NUM_KEYS))) begin
			key_q[cfg.index[magma_pkg::KEY_IDX_W-1:0]] <= cfg.data;
		end
	end

	assign sv[0]      = blk_in.valid;
	assign sd[0].kind = blk_in.kind;
	assign sd[0].a0   = blk_in.block_in[31:0];
	assign sd[0].a1   = blk_in.block_in[63:32];
	assign blk_in.ready = sr[0];

	for (genvar g = 0; g < NR; g++) begin : g_round
		localparam magma_pkg::key_idx_t EK = magma_pkg::enc_key_idx(g);
		localparam magma_pkg::key_idx_t DK = magma_pkg::enc_key_idx(NR - 1 - g);

		assign rk[g]     = sd[g].kind ? key_q[DK] : key_q[EK];
		assign sv_vec[g] = sv[g+1];

		magma_feistel_stage u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (sv[g]),
			.up_ready (sr[g]),
			.up_data  (sd[g]),
			.key      (rk[g]),
			.dn_valid (sv[g+1]),
			.dn_ready (sr[g+1]),
			.dn_data  (sd[g+1])
		);
	end

	assign sr[NR]            = blk_out.ready;
	assign blk_out.valid     = sv[NR];
	assign blk_out.block_out = {sd[NR].a0, sd[NR].a1};

`include "magma_block_cipher_top_assert.svh"

	// Input is refused only when every stage holds a block and the output is stalled.
	`MAGMA_ASSERT_IMP(a_full_when_blocked, !blk_in.ready, (&sv_vec) && !blk_out.ready)
	// A stalled first stage keeps its block.
	`MAGMA_ASSERT_NEXT(a_s1_holds, sv[1] && !sr[1], sv[1] && $stable(sd[1]))
	// A delivered result with nothing behind it leaves the output empty.
	`MAGMA_ASSERT_NEXT(a_drain, blk_out.valid && blk_out.ready && !sv[NR-1], !blk_out.valid)

endmodule

`default_nettype wire

/* tb/sv/magma_cipher_checker.sv */
`default_nettype none

module magma_cipher_checker (
	input  wire   clk,
	input  wire   arst_n,
	magma_in_if   blk_in,
	magma_out_if  blk_out,
	magma_cfg_if  cfg,
	output int    mismatches,
	output int    pending,
	output int    blocks_checked
);

	// The eight substitution boxes; box i occupies bits [64*i +: 64], entry n at [4*n +: 4].
	localparam logic [511:0] SUBST = {
		64'h2bc96af43850de71, 64'h73ad0b4fc19652e8,
		64'h0e34187bac296fd5, 64'hc24be390d618a5f7,
		64'hb9e35a076f4d128c, 64'h069c471edaf2853b,
		64'hf0db74e1c5a93286, 64'h1f307d8e9b5a264c
	};

	magma_pkg::word_t key_words [magma_pkg::NUM_KEYS];
	logic [63:0]      predicted_blocks [$];
	logic [63:0]      want;

	function automatic logic [63:0] magma_transform(input logic decrypt, input logic [63:0] blk);
		magma_pkg::word_t a0;
		magma_pkg::word_t a1;
		magma_pkg::word_t sum;
		magma_pkg::word_t sub;
		magma_pkg::word_t nxt;
		int               sched;
		magma_pkg::key_idx_t kidx;
		a0 = blk[31:0];
		a1 = blk[63:32];
		for (int r = 0; r < 32; r++) begin
			sched = decrypt ? 31 - r : r;
			kidx = magma_pkg::key_idx_t'(sched < 24 ? sched % 8 : 7 - sched % 8);
			sum = a0 + key_words[kidx];
			for (int i = 0; i < 8; i++) begin
				sub[4*i +: 4] = SUBST[64*i + 4*sum[4*i +: 4] +: 4];
			end
			nxt = a1 ^ {sub[20:0], sub[31:21]};
			a1 = a0;
			a0 = nxt;
		end
		return {a0, a1};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predicted_blocks.delete();
			for (int i = 0; i < magma_pkg::NUM_KEYS; i++) begin
				key_words[i] = '0;
			end
			mismatches <= 0;
			pending <= 0;
			blocks_checked <= 0;
		end else begin
			if (cfg.valid && cfg.ready && cfg.index < magma_pkg::NUM_KEYS) begin
				key_words[cfg.index[magma_pkg::KEY_IDX_W-1:0]] = cfg.data;
			end
			if (blk_in.valid && blk_in.ready) begin
				predicted_blocks.insert(predicted_blocks.size(),
					magma_transform(blk_in.kind, blk_in.block_in));
			end
			if (blk_out.valid && blk_out.ready) begin
				if (predicted_blocks.size() == 0) begin
					$error("block_out unexpected: expected none, actual %h", blk_out.block_out);
					mismatches <= mismatches + 1;
				end else begin
					want = predicted_blocks.pop_front();
					if (blk_out.block_out !== want) begin
						$error("block_out mismatch: expected %h, actual %h", want,
							blk_out.block_out);
						mismatches <= mismatches + 1;
					end
				end
				blocks_checked <= blocks_checked + 1;
			end
			pending <= predicted_blocks.size();
		end
	end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;
	localparam logic [magma_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_INDEX =
		magma_pkg::CFG_IDX_W'(magma_pkg::NUM_KEYS);
	localparam logic [magma_pkg::CFG_IDX_W-1:0] LAST_UNUSED_INDEX = '1;
	localparam int PIPE_DEPTH = 32;
	localparam int STALL_LIMIT = 4000;
	localparam int SEGMENTS = 8;
	localparam int SEGMENT_BLOCKS = 172;
	localparam logic [255:0] STD_KEY =
		256'hffeeddccbbaa99887766554433221100f0f1f2f3f4f5f6f7f8f9fafbfcfdfeff;
	localparam logic [255:0] ALT_KEY =
		256'h00000000ffffffff00000000ffffffff00000000ffffffff00000000ffffffff;
	localparam logic [63:0] STD_PLAIN = 64'hfedcba9876543210;
	localparam logic [63:0] STD_CIPHER = 64'h4ee901e5c2d8ca3d;

	logic         clk;
	logic         arst_n;
	int           idle_pct;
	int           stall_pct;
	int           idle_cycles;
	int           mismatches;
	int           pending;
	int           blocks_checked;
	int           blocks_sent;
	int           decrypts_sent;
	int           key_sets;
	logic [255:0] key;
	logic [63:0]  blk;

	magma_in_if  blk_in_ch ();
	magma_out_if blk_out_ch ();
	magma_cfg_if cfg_ch ();

	magma_block_cipher_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.blk_in  (blk_in_ch),
		.blk_out (blk_out_ch),
		.cfg     (cfg_ch)
	);

	magma_cipher_checker cipher_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.blk_in         (blk_in_ch),
		.blk_out        (blk_out_ch),
		.cfg            (cfg_ch),
		.mismatches     (mismatches),
		.pending        (pending),
		.blocks_checked (blocks_checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		blk_out_ch.ready <= $urandom_range(99) >= stall_pct;
	end

	always @(posedge clk) begin
		if (!arst_n || (blk_in_ch.valid && blk_in_ch.ready)
				|| (blk_out_ch.valid && blk_out_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic [magma_pkg::CFG_IDX_W-1:0] idx,
			input magma_pkg::word_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_key(input logic [255:0] new_key);
		for (int i = 0; i < magma_pkg::NUM_KEYS; i++) begin
			write_reg(magma_pkg::CFG_IDX_W'(i), new_key[255 - 32*i -: 32]);
		end
		key_sets++;
	endtask

	task automatic send_block(input logic op, input logic [63:0] data);
		while ($urandom_range(99) < idle_pct) begin
			blk_in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		blk_in_ch.valid <= 1'b1;
		blk_in_ch.kind <= op;
		blk_in_ch.block_in <= data;
		do @(posedge clk); while (!blk_in_ch.ready);
		blocks_sent++;
		if (op == OP_DECRYPT) begin
			decrypts_sent++;
		end
	endtask

	task automatic drain;
		blk_in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		idle_cycles = 0;
		blocks_sent = 0;
		decrypts_sent = 0;
		key_sets = 0;
		blk_in_ch.valid = 1'b0;
		blk_in_ch.kind = OP_ENCRYPT;
		blk_in_ch.block_in = '0;
		blk_out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Keys straight out of reset are all zero.
		send_block(OP_ENCRYPT, '0);
		send_block(OP_DECRYPT, '0);
		send_block(OP_ENCRYPT, '1);
		send_block(OP_DECRYPT, '1);
		drain();

		load_key(STD_KEY);
		send_block(OP_ENCRYPT, STD_PLAIN);
		send_block(OP_DECRYPT, STD_CIPHER);
		send_block(OP_ENCRYPT, '0);
		send_block(OP_ENCRYPT, '1);
		send_block(OP_DECRYPT, '0);
		send_block(OP_ENCRYPT, 64'h00000000ffffffff);
		send_block(OP_DECRYPT, 64'hffffffff00000000);
		send_block(OP_ENCRYPT, 64'h5555555555555555);
		send_block(OP_DECRYPT, 64'haaaaaaaaaaaaaaaa);
		send_block(OP_ENCRYPT, 64'h8000000000000001);
		drain();

		// Writes to indexes past the key words must leave the key untouched.
		write_reg(FIRST_UNUSED_INDEX, '1);
		write_reg(LAST_UNUSED_INDEX, '1);
		send_block(OP_ENCRYPT, STD_PLAIN);
		drain();

		load_key('1);
		send_block(OP_ENCRYPT, '0);
		send_block(OP_DECRYPT, '0);
		send_block(OP_ENCRYPT, '1);
		send_block(OP_DECRYPT, '1);
		drain();

		for (int s = 0; s < SEGMENTS; s++) begin
			if (s == 3) begin
				key = '0;
			end else if (s == 6) begin
				key = ALT_KEY;
			end else begin
				for (int i = 0; i < magma_pkg::NUM_KEYS; i++) begin
					key[32*i +: 32] = $urandom;
				end
			end
			load_key(key);
			write_reg(magma_pkg::CFG_IDX_W'($urandom_range(2**magma_pkg::CFG_IDX_W - 1,
				magma_pkg::NUM_KEYS)), $urandom);
			case (s % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 58;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 58;
				end
				default: begin
					idle_pct = 12;
					stall_pct = 12;
				end
			endcase
			for (int n = 0; n < SEGMENT_BLOCKS; n++) begin
				case ($urandom_range(9))
					0: blk = '0;
					1: blk = '1;
					2: blk = 64'h1 << $urandom_range(63);
					3: blk = ~(64'h1 << $urandom_range(63));
					default: blk = {$urandom, $urandom};
				endcase
				send_block($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT, blk);
				if (n == SEGMENT_BLOCKS / 2) begin
					drain();
				end
			end
			drain();
		end

		idle_pct = 0;
		stall_pct = 0;
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		$display("Checked %0d of %0d blocks (%0d decryptions) under %0d key loads,",
			blocks_checked, blocks_sent, decrypts_sent, key_sets);
		$display("with ignored writes to unused indexes and four mixes of gaps and stalls.");
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
